// File: rtl/core/text_console_cursor_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console cursor writer: assertion macros
// Shared concurrent assertion helpers for the console block.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_DEFINES_SVH

// Check a property outside reset.
`define TCCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TCCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor writer package
// Screen geometry, codes, controller states and control structs.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(CELL_COUNT);

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR = 1'b1;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'd2;
    localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'd0;

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_IDLE,
        S_DECODE,
        S_SCROLL_RD,
        S_SCROLL_WR,
        S_WRITE,
        S_CLEAR,
        S_READ_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic cnt_clr;
        logic cnt_inc;
        logic rd_cnt;
        logic rd_cell;
        logic wr_char;
        logic wr_cpy;
        logic wr_blank;
        logic blank_rst;
        logic cur_home;
        logic cur_nl;
        logic cur_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_put;
        logic is_nl;
        logic is_clr;
        logic is_rd_ok;
        logic col_full;
        logic row_last;
        logic cnt_bottom;
        logic cnt_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/core/tccw_if.sv
// ----------------------------------------------------------------------------
// Text console cursor writer channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tccw_in_if;
    logic                          valid;
    logic                          ready;
    logic [tccw_pkg::OP_W-1:0]     operation;
    logic [tccw_pkg::CHAR_W-1:0]   character;
    logic [tccw_pkg::ROW_W-1:0]    read_row;
    logic [tccw_pkg::COL_W-1:0]    read_col;

    modport source (output valid, operation, character, read_row, read_col, input ready);
    modport sink   (input valid, operation, character, read_row, read_col, output ready);
endinterface

interface tccw_out_if;
    logic                          valid;
    logic                          ready;
    logic [tccw_pkg::ROW_W-1:0]    cursor_row;
    logic [tccw_pkg::COL_W-1:0]    cursor_col;
    logic [tccw_pkg::CHAR_W-1:0]   cell_char;
    logic [tccw_pkg::ATTR_W-1:0]   cell_attr;

    modport source (output valid, cursor_row, cursor_col, cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cell_char, cell_attr, output ready);
endinterface

// File: rtl/core/tccw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// Sequences puts, scrolls, clears and reads over the screen datapath.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tccw_pkg::t_sts   i_sts,
    output tccw_pkg::t_cmd   o_cmd
);

    tccw_pkg::t_state r_state;
    tccw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccw_pkg::S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tccw_pkg::S_RST_CLR: begin
                // blank with the reset attribute, whatever config says
                o_cmd.wr_blank  = 1'b1;
                o_cmd.blank_rst = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = tccw_pkg::S_IDLE;
                end
            end
            tccw_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take    = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = tccw_pkg::S_DECODE;
                end
            end
            tccw_pkg::S_DECODE: begin
                if (i_sts.is_put) begin
                    if (i_sts.is_nl || i_sts.col_full) begin
                        if (i_sts.row_last) begin
                            n_state = tccw_pkg::S_SCROLL_RD;
                        end else begin
                            o_cmd.cur_nl = 1'b1;
                            n_state = i_sts.is_nl ? tccw_pkg::S_DONE : tccw_pkg::S_WRITE;
                        end
                    end else begin
                        n_state = tccw_pkg::S_WRITE;
                    end
                end else if (i_sts.is_clr) begin
                    n_state = tccw_pkg::S_CLEAR;
                end else if (i_sts.is_rd_ok) begin
                    o_cmd.rd_cell = 1'b1;
                    n_state       = tccw_pkg::S_READ_WAIT;
                end else begin
                    n_state = tccw_pkg::S_DONE;
                end
            end
            tccw_pkg::S_SCROLL_RD: begin
                if (!i_sts.cnt_bottom) begin
                    o_cmd.rd_cnt = 1'b1;
                    n_state      = tccw_pkg::S_SCROLL_WR;
                end else begin
                    o_cmd.wr_blank = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                    if (i_sts.cnt_last) begin
                        o_cmd.cur_nl = 1'b1;
                        n_state = i_sts.is_nl ? tccw_pkg::S_DONE : tccw_pkg::S_WRITE;
                    end
                end
            end
            tccw_pkg::S_SCROLL_WR: begin
                o_cmd.wr_cpy  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = tccw_pkg::S_SCROLL_RD;
            end
            tccw_pkg::S_WRITE: begin
                o_cmd.wr_char = 1'b1;
                o_cmd.cur_inc = 1'b1;
                n_state       = tccw_pkg::S_DONE;
            end
            tccw_pkg::S_CLEAR: begin
                o_cmd.wr_blank = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.cur_home = 1'b1;
                    n_state        = tccw_pkg::S_DONE;
                end
            end
            tccw_pkg::S_READ_WAIT, tccw_pkg::S_DONE: begin
                // hold here until the result register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tccw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tccw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/tccw_dp.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Item latch, cursor, config registers, screen RAM, sweep counter, result.
// ----------------------------------------------------------------------------
module tccw_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tccw_pkg::ATTR_W-1:0]         i_cfg_wdata,
    input  logic [tccw_pkg::OP_W-1:0]           i_operation,
    input  logic [tccw_pkg::CHAR_W-1:0]         i_character,
    input  logic [tccw_pkg::ROW_W-1:0]          i_read_row,
    input  logic [tccw_pkg::COL_W-1:0]          i_read_col,
    input  tccw_pkg::t_cmd                      i_cmd,
    output tccw_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tccw_pkg::ROW_W-1:0]          o_cursor_row,
    output logic [tccw_pkg::COL_W-1:0]          o_cursor_col,
    output logic [tccw_pkg::CHAR_W-1:0]         o_cell_char,
    output logic [tccw_pkg::ATTR_W-1:0]         o_cell_attr
);

    localparam int AW = tccw_pkg::ADDR_W;

    logic [tccw_pkg::OP_W-1:0]   r_op;
    logic [tccw_pkg::CHAR_W-1:0] r_ch;
    logic [tccw_pkg::ROW_W-1:0]  r_rr;
    logic [tccw_pkg::COL_W-1:0]  r_rc;
    logic [tccw_pkg::ROW_W-1:0]  r_row;
    logic [tccw_pkg::COL_W-1:0]  r_col;
    logic [tccw_pkg::ATTR_W-1:0] r_text_attr;
    logic [tccw_pkg::ATTR_W-1:0] r_blank_attr;
    logic [AW-1:0]               r_cnt;
    logic                        r_out_vld;
    logic [tccw_pkg::ROW_W-1:0]  r_out_row;
    logic [tccw_pkg::COL_W-1:0]  r_out_col;
    logic [tccw_pkg::CELL_W-1:0] r_out_cell;

    logic [AW-1:0]               cur_idx;
    logic [AW-1:0]               cell_idx;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [tccw_pkg::CELL_W-1:0] wr_data;
    logic [tccw_pkg::ATTR_W-1:0] blank_attr;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [tccw_pkg::CELL_W-1:0] rd_data;

    // latch the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op <= i_operation;
            r_ch <= i_character;
            r_rr <= i_read_row;
            r_rc <= i_read_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr  <= tccw_pkg::TEXT_ATTR_RST;
            r_blank_attr <= tccw_pkg::BLANK_ATTR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tccw_pkg::CFG_TEXT_ATTR) begin
                r_text_attr <= i_cfg_wdata;
            end
            if (i_cfg_idx == tccw_pkg::CFG_BLANK_ATTR) begin
                r_blank_attr <= i_cfg_wdata;
            end
        end
    end

    // cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.cur_home) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.cur_nl) begin
            r_col <= '0;
            if (!o_sts.row_last) begin
                r_row <= r_row + tccw_pkg::ROW_W'(1);
            end
        end else if (i_cmd.cur_inc) begin
            r_col <= r_col + tccw_pkg::COL_W'(1);
        end
    end

    // sweep counter for clear and scroll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    assign cur_idx  = AW'(r_row) * AW'(tccw_pkg::SCREEN_WIDTH) + AW'(r_col);
    assign cell_idx = AW'(r_rr) * AW'(tccw_pkg::SCREEN_WIDTH) + AW'(r_rc);

    assign blank_attr = i_cmd.blank_rst ? tccw_pkg::BLANK_ATTR_RST : r_blank_attr;
    assign wr_en   = i_cmd.wr_char | i_cmd.wr_cpy | i_cmd.wr_blank;
    assign wr_addr = i_cmd.wr_char ? cur_idx : r_cnt;
    always_comb begin
        if (i_cmd.wr_char) begin
            wr_data = {r_ch, r_text_attr};
        end else if (i_cmd.wr_cpy) begin
            wr_data = rd_data;
        end else begin
            wr_data = {tccw_pkg::BLANK_CHAR, blank_attr};
        end
    end

    assign rd_en   = i_cmd.rd_cnt | i_cmd.rd_cell;
    assign rd_addr = i_cmd.rd_cnt ? (r_cnt + AW'(tccw_pkg::SCREEN_WIDTH)) : cell_idx;

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (tccw_pkg::CELL_COUNT)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        o_sts.is_put   = (r_op == tccw_pkg::OP_PUT);
        o_sts.is_nl    = (r_ch == tccw_pkg::NEWLINE_CHAR);
        o_sts.is_clr   = (r_op == tccw_pkg::OP_CLEAR);
        o_sts.is_rd_ok = (r_op == tccw_pkg::OP_READ)
                       && (r_rr < tccw_pkg::ROW_W'(tccw_pkg::SCREEN_HEIGHT))
                       && (r_rc < tccw_pkg::COL_W'(tccw_pkg::SCREEN_WIDTH));
        o_sts.col_full   = (r_col >= tccw_pkg::COL_W'(tccw_pkg::SCREEN_WIDTH));
        o_sts.row_last   = (r_row == tccw_pkg::ROW_W'(tccw_pkg::SCREEN_HEIGHT - 1));
        o_sts.cnt_bottom = (r_cnt >= AW'(tccw_pkg::CELL_COUNT - tccw_pkg::SCREEN_WIDTH));
        o_sts.cnt_last   = (r_cnt == AW'(tccw_pkg::CELL_COUNT - 1));
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_cell <= o_sts.is_rd_ok ? rd_data : '0;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_cell_char  = r_out_cell[tccw_pkg::CELL_W-1:tccw_pkg::ATTR_W];
    assign o_cell_attr  = r_out_cell[tccw_pkg::ATTR_W-1:0];

endmodule

// File: rtl/core/text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// Text console cursor writer
// Character-cell screen with cursor, line wrap, scroll, clear and cell read.
// ----------------------------------------------------------------------------
// Channel    Dir   Handshake       Payload
// i_item     in    valid/ready     operation, character, read_row, read_col
// o_result   out   valid/ready     cursor_row, cursor_col, cell_char, cell_attr
// i_cfg_*    in    write enable    index 0 text_attr, index 1 blank_attr
//
// One item at a time. A plain put steps through decode, write and report before
// the next ready, a newline or a read through decode and report. A scroll
// copies each moved cell with a read and a write, then blanks each bottom-row
// cell; a clear blanks every cell. After reset a clearing pass runs over every
// cell with i_item.ready low. A stalled result holds in its register; the next
// item is taken meanwhile and waits at its end for the register to free up.
// ----------------------------------------------------------------------------
`include "text_console_cursor_writer_defines.svh"

module text_console_cursor_writer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tccw_pkg::ATTR_W-1:0]     i_cfg_wdata,
    tccw_in_if.sink                         i_item,
    tccw_out_if.source                      o_result
);

    tccw_pkg::t_cmd cmd;
    tccw_pkg::t_sts sts;

    logic       item_acc;
    logic       cursor_ok;
    logic [2:0] wr_sel;

    // sequence each item: decode, scroll or clear sweep, write or cell read, report
    tccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // hold cursor, config, screen RAM and the result register
    tccw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_operation  (i_item.operation),
        .i_character  (i_item.character),
        .i_read_row   (i_item.read_row),
        .i_read_col   (i_item.read_col),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_result.valid),
        .i_out_ready  (o_result.ready),
        .o_cursor_row (o_result.cursor_row),
        .o_cursor_col (o_result.cursor_col),
        .o_cell_char  (o_result.cell_char),
        .o_cell_attr  (o_result.cell_attr)
    );

    assign item_acc  = i_item.valid && i_item.ready;
    assign cursor_ok = (o_result.cursor_row < tccw_pkg::ROW_W'(tccw_pkg::SCREEN_HEIGHT))
                    && (o_result.cursor_col <= tccw_pkg::COL_W'(tccw_pkg::SCREEN_WIDTH));
    assign wr_sel    = {cmd.wr_char, cmd.wr_cpy, cmd.wr_blank};

    // one item in flight: no second accept right after one
    `TCCW_ASSERT(a_one_item, i_clk, i_rst_n, item_acc |=> !i_item.ready, "accept while busy")
    // only one source drives the RAM write port in any cycle
    `TCCW_ASSERT(a_wr_excl, i_clk, i_rst_n, $onehot0(wr_sel), "conflicting screen writes")
    // a reported cursor stays on screen, column at most one past the line
    `TCCW_ASSERT(a_cursor_range, i_clk, i_rst_n, o_result.valid |-> cursor_ok, "bad cursor")
    // clearing pass follows reset: no item taken as reset drops
    `TCCW_ASSERT_ALWAYS(a_rst_clear, i_clk, $rose(i_rst_n) |-> !i_item.ready, "early ready")

endmodule
